>>> hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, types and index helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned WordW = 32;
  localparam int unsigned OccW  = 5;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned StW   = 2;

  // Output tdata: pop_value, then occupancy, padded to whole bytes
  localparam int unsigned OutDataW = ((WordW + OccW + 7) / 8) * 8;

  localparam logic [CmdW-1:0] CmdPushFront = 2'd0;
  localparam logic [CmdW-1:0] CmdPushRear  = 2'd1;
  localparam logic [CmdW-1:0] CmdPopFront  = 2'd2;
  localparam logic [CmdW-1:0] CmdPopRear   = 2'd3;

  localparam logic [StW-1:0] StOk        = 2'd0;
  localparam logic [StW-1:0] StUnderflow = 2'd1;
  localparam logic [StW-1:0] StOverflow  = 2'd2;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [WordW-1:0] word_t;

  // Memory request and result info from the pointer control
  typedef struct packed {
    logic            we;
    logic            re;
    idx_t            addr;
    logic [StW-1:0]  status;
    logic [OccW-1:0] occupancy;
  } dq_req_t;

  // Ring add: base < Depth and offset < Depth, so one subtract folds it back
  function automatic idx_t wrap_add(input idx_t base, input logic [IdxW:0] offset);
    logic [IdxW:0] sum;
    sum = {1'b0, base} + offset;
    if (sum >= (IdxW + 1)'(Depth)) begin
      sum = sum - (IdxW + 1)'(Depth);
    end
    return sum[IdxW-1:0];
  endfunction

  function automatic idx_t wrap_dec(input idx_t base);
    idx_t res;
    if (base == '0) begin
      res = IdxW'(Depth - 1);
    end else begin
      res = base - idx_t'(1);
    end
    return res;
  endfunction

endpackage

>>> hdl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                         wdata_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Head index and entry count; decodes a command into a RAM access and status.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [dq_pkg::CmdW-1:0] command_i,
  output dq_pkg::dq_req_t         req_o
);

  dq_pkg::idx_t head_q, head_d;
  dq_pkg::cnt_t count_q, count_d;
  logic         full, empty;

  assign full  = (count_q == dq_pkg::CntW'(dq_pkg::Depth));
  assign empty = (count_q == '0);

  always_comb begin
    head_d        = head_q;
    count_d       = count_q;
    req_o.we      = 1'b0;
    req_o.re      = 1'b0;
    req_o.addr    = head_q;
    req_o.status  = dq_pkg::StOk;
    unique case (command_i)
      dq_pkg::CmdPushFront: begin
        if (full) begin
          req_o.status = dq_pkg::StOverflow;
        end else begin
          req_o.we   = 1'b1;
          req_o.addr = dq_pkg::wrap_dec(head_q);
          head_d     = req_o.addr;
          count_d    = count_q + dq_pkg::cnt_t'(1);
        end
      end
      dq_pkg::CmdPushRear: begin
        if (full) begin
          req_o.status = dq_pkg::StOverflow;
        end else begin
          req_o.we   = 1'b1;
          req_o.addr = dq_pkg::wrap_add(head_q, (dq_pkg::IdxW + 1)'(count_q));
          count_d    = count_q + dq_pkg::cnt_t'(1);
        end
      end
      dq_pkg::CmdPopFront: begin
        if (empty) begin
          req_o.status = dq_pkg::StUnderflow;
        end else begin
          req_o.re   = 1'b1;
          req_o.addr = head_q;
          head_d     = dq_pkg::wrap_add(head_q, (dq_pkg::IdxW + 1)'(1));
          count_d    = count_q - dq_pkg::cnt_t'(1);
        end
      end
      dq_pkg::CmdPopRear: begin
        if (empty) begin
          req_o.status = dq_pkg::StUnderflow;
        end else begin
          req_o.re   = 1'b1;
          req_o.addr = dq_pkg::wrap_add(head_q,
                                        (dq_pkg::IdxW + 1)'(count_q - dq_pkg::cnt_t'(1)));
          count_d    = count_q - dq_pkg::cnt_t'(1);
        end
      end
      default: begin
        req_o.status = dq_pkg::StOk;
      end
    endcase
    req_o.occupancy = dq_pkg::OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

endmodule

>>> hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque of signed 32-bit words in a ring-addressed single-port RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_axis): tuser carries the command (push front, push rear,
//   pop front, pop rear), tdata the word to push (ignored on pops).
//   Output channel (m_axis): one item per command. tdata carries the popped
//   word (zero on pushes and failed pops) and the occupancy after the command;
//   tuser carries the status (ok, underflow, overflow).
//   A command updates head and count in the cycle it is taken and issues one
//   RAM access; a pop's word comes from the RAM's registered read port while the
//   command info waits in the pending register, and both then go to the output
//   register. A new command is taken only once the previous one has left the
//   pending register, so no command is taken while a RAM read is outstanding.
//   Reset: the queue is empty, head index zero; the RAM is not cleared.
//   Stall: while the output item waits on m_axis_tready_i the block holds it
//   and accepts no new item unless the output register frees in that cycle.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [dq_pkg::WordW-1:0]    s_axis_tdata_i,  // [31:0] push_value
  input  logic [dq_pkg::CmdW-1:0]     s_axis_tuser_i,  // [1:0] command
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [dq_pkg::OutDataW-1:0] m_axis_tdata_o,  // [31:0] pop_value,
                                                       // [36:32] occupancy, rest zero
  output logic [dq_pkg::StW-1:0]      m_axis_tuser_o   // [1:0] status
);

  dq_pkg::dq_req_t req;
  logic            accept;
  dq_pkg::word_t   rdata;

  logic                    p_valid_q;
  logic                    p_pop_q;
  logic [dq_pkg::StW-1:0]  p_status_q;
  logic [dq_pkg::OccW-1:0] p_occ_q;

  logic                    out_valid_q;
  dq_pkg::word_t           out_value_q;
  logic [dq_pkg::StW-1:0]  out_status_q;
  logic [dq_pkg::OccW-1:0] out_occ_q;

  assign s_axis_tready_o = !p_valid_q && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  dq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .command_i (s_axis_tuser_i),
    .req_o     (req)
  );

  dq_ram #(
    .Width (dq_pkg::WordW),
    .Depth (dq_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept && req.we),
    .re_i    (accept && req.re),
    .addr_i  (req.addr),
    .wdata_i (s_axis_tdata_i),
    .rdata_o (rdata)
  );

  // Hold command info while the RAM read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_pop_q    <= req.re;
      p_status_q <= req.status;
      p_occ_q    <= req.occupancy;
    end
  end

  // Output register is always free when the pending item advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p_valid_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_valid_q) begin
      out_value_q  <= p_pop_q ? rdata : '0;
      out_status_q <= p_status_q;
      out_occ_q    <= p_occ_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = dq_pkg::OutDataW'({out_occ_q, out_value_q});
  assign m_axis_tuser_o  = out_status_q;

endmodule

>>> hdl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the deque's input and result channels, bound to the
// top level.
// ----------------------------------------------------------------------------
module dq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [dq_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [dq_pkg::StW-1:0]      m_axis_tuser_o
);

  logic [dq_pkg::OccW-1:0] occ;
  logic [dq_pkg::WordW-1:0] value;

  assign occ   = m_axis_tdata_o[dq_pkg::WordW +: dq_pkg::OccW];
  assign value = m_axis_tdata_o[dq_pkg::WordW-1:0];

  // Underflow is only possible on an empty queue
  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == dq_pkg::StUnderflow |-> occ == '0)
    else $error("underflow reported with nonzero occupancy");

  // Overflow is only possible on a full queue
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == dq_pkg::StOverflow
      |-> occ == dq_pkg::OccW'(dq_pkg::Depth))
    else $error("overflow reported below full occupancy");

  // A failed command carries no word
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != dq_pkg::StOk |-> value == '0)
    else $error("failed command returned a nonzero word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output item dropped or changed");

  // Hold off the input for the cycle after an item is taken
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input item taken while the previous one is pending");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
